// ----- hdl/gest_pkg.sv -----
// Shared constants for the gamepad event state tracker.
package gest_pkg;

    // Default table sizes
    localparam int MAX_BUTTONS_DEF = 64;
    localparam int MAX_AXES_DEF    = 16;

    // Field widths
    localparam int ACTION_W   = 3;
    localparam int SLOT_W     = 6;
    localparam int ETYPE_W    = 2;
    localparam int CODE_W     = 10;
    localparam int VALUE_W    = 32;
    localparam int MASK_W     = 64;
    localparam int AIDX_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int NB_W       = 7;
    localparam int NA_W       = 5;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_LOAD_BUTTON = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_AXIS   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_EVENT       = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FRAME       = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FOCUS_LOST  = 3'd4;

    // Event types
    localparam logic [ETYPE_W-1:0] EVT_KEY = 2'd0;
    localparam logic [ETYPE_W-1:0] EVT_ABS = 2'd1;
    localparam logic [ETYPE_W-1:0] EVT_REL = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_BUTTONS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_AXES    = 1'b1;

    // Report kinds
    localparam logic RPT_AXIS   = 1'b0;
    localparam logic RPT_BUTTON = 1'b1;

    // Normaliser divider: magnitude dividend bits, one quotient bit per step
    localparam int DIV_STEPS = 50;

endpackage

// ----- hdl/gest_in_if.sv -----
// Input and result channel interfaces of the gamepad event state tracker.
interface gest_in_if import gest_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [SLOT_W-1:0]          slot;
    logic [ETYPE_W-1:0]         event_type;
    logic [CODE_W-1:0]          event_code;
    logic signed [VALUE_W-1:0]  event_value;
    logic                       axis_absolute;
    logic signed [VALUE_W-1:0]  axis_min;
    logic signed [VALUE_W-1:0]  axis_max;

    modport source (output valid, action, slot, event_type, event_code, event_value,
                    axis_absolute, axis_min, axis_max, input ready);
    modport sink   (input valid, action, slot, event_type, event_code, event_value,
                    axis_absolute, axis_min, axis_max, output ready);
endinterface

interface gest_out_if import gest_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic                       report_kind;
    logic [AIDX_W-1:0]          axis_index;
    logic signed [VALUE_W-1:0]  axis_value;
    logic signed [VALUE_W-1:0]  axis_change;
    logic [MASK_W-1:0]          buttons_down;
    logic [MASK_W-1:0]          buttons_changed;
    logic                       last;

    modport source (output valid, report_kind, axis_index, axis_value, axis_change,
                    buttons_down, buttons_changed, last, input ready);
    modport sink   (input valid, report_kind, axis_index, axis_value, axis_change,
                    buttons_down, buttons_changed, last, output ready);
endinterface

// ----- hdl/gamepad_event_state_tracker.sv -----
// Gamepad event state tracker: slot tables, axis state memories and frame reporting.
//
// One input transaction is handled at a time; ready is high only while the block is idle.
// A load writes its table on acceptance. A key event scans the button code memory, one
// slot a cycle. An axis event scans the axis table likewise; a relative one then does a
// read-modify-write of the axis value, an absolute one runs the bit-serial normalising
// divider. A frame update or focus loss walks the axis memories (all MAX_AXES slots for a
// frame, the slots in use for focus loss) and then sends the button report, but the first
// frame only takes snapshots; results wait in an output register, and the walk stalls
// while it is full.
// No clearing pass is needed after reset.
module gamepad_event_state_tracker import gest_pkg::*; #(
    parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
    parameter int MAX_AXES    = MAX_AXES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gest_in_if.sink               in_ch,
    gest_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int BIW = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam int AIW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;

    typedef struct packed {
        logic [CODE_W-1:0]         code;
        logic                      absolute;
        logic                      one_sided;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
    } axis_cfg_t;

    typedef struct packed {
        logic                      kind;
        logic [AIDX_W-1:0]         idx;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] change;
        logic [MASK_W-1:0]         down;
        logic [MASK_W-1:0]         changed;
        logic                      last;
    } report_t;

    typedef enum logic [3:0] {
        S_IDLE, S_BSCAN, S_ASCAN, S_REL_WR, S_DIV, S_DIV_END,
        S_WALK_RD, S_WALK_CHK, S_BTN_RPT
    } state_t;

    function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [51:0] x);
        if (x > 52'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -52'sd2147483648)
            return 32'sh80000000;
        else
            return x[VALUE_W-1:0];
    endfunction

    // Configuration registers
    logic [NB_W-1:0] num_buttons_reg;
    logic [NA_W-1:0] num_axes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_buttons_reg <= '0;
            num_axes_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NUM_BUTTONS: num_buttons_reg <= cfg_data[NB_W-1:0];
                REG_NUM_AXES:    num_axes_reg    <= cfg_data[NA_W-1:0];
                default:         ;
            endcase
        end
    end

    logic [NB_W-1:0]        nb;
    logic [NA_W-1:0]        na;
    logic [MAX_BUTTONS-1:0] btn_mask;

    assign nb = (num_buttons_reg > NB_W'(MAX_BUTTONS)) ? NB_W'(MAX_BUTTONS) : num_buttons_reg;
    assign na = (num_axes_reg > NA_W'(MAX_AXES)) ? NA_W'(MAX_AXES) : num_axes_reg;

    always_comb
    begin
        for (int j = 0; j < MAX_BUTTONS; j++)
            btn_mask[j] = NB_W'(j) < nb;
    end

    // Control state
    state_t                    state_reg;
    logic [NB_W-1:0]           cnt_reg;
    logic                      cmp_vld_reg;
    logic [NB_W-1:0]           cmp_idx_reg;
    logic [AIW-1:0]            idx_reg;
    logic [CODE_W-1:0]         op_code_reg;
    logic signed [VALUE_W-1:0] op_value_reg;
    logic                      op_abs_reg;
    logic                      op_focus_reg;
    logic [NA_W-1:0]           walk_lim_reg;
    logic                      first_done_reg;
    logic [MAX_BUTTONS-1:0]    pressed_now_reg;
    logic [MAX_BUTTONS-1:0]    pressed_snap_reg;
    logic                      out_valid_reg;
    report_t                   out_reg;

    // Divider state
    logic [32:0]               rem_reg;
    logic [DIV_STEPS-1:0]      dvd_reg;
    logic [DIV_STEPS-1:0]      quo_reg;
    logic [32:0]               dsr_reg;
    logic [5:0]                div_cnt_reg;
    logic                      neg_reg;
    logic                      sym_reg;
    logic                      div_zero_reg;

    logic accept;
    assign in_ch.ready = (state_reg == S_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // Button code memory
    logic [CODE_W-1:0] btn_code_mem [MAX_BUTTONS];
    logic [CODE_W-1:0] btn_rd_reg;
    logic              btn_we;
    logic              btn_re;

    assign btn_we = accept && (in_ch.action == ACT_LOAD_BUTTON)
                    && (NB_W'(in_ch.slot) < NB_W'(MAX_BUTTONS));

    always_ff @(posedge clk)
    begin
        if (btn_we)
            btn_code_mem[in_ch.slot[BIW-1:0]] <= in_ch.event_code;
        if (btn_re)
            btn_rd_reg <= btn_code_mem[cnt_reg[BIW-1:0]];
    end

    // Axis configuration memory, one-sided test worked out at load
    axis_cfg_t axis_cfg_mem [MAX_AXES];
    axis_cfg_t cfg_rd_reg;
    axis_cfg_t cfg_wdata;
    logic      cfg_mem_we;
    logic      cfg_re;
    logic [31:0] abs_lo;
    logic [31:0] abs_hi;
    logic [35:0] lo_x10;

    assign cfg_mem_we = accept && (in_ch.action == ACT_LOAD_AXIS)
                        && (NB_W'(in_ch.slot) < NB_W'(MAX_AXES));
    assign abs_lo = in_ch.axis_min[31] ? 32'(-in_ch.axis_min) : 32'(in_ch.axis_min);
    assign abs_hi = in_ch.axis_max[31] ? 32'(-in_ch.axis_max) : 32'(in_ch.axis_max);
    assign lo_x10 = ({4'b0, abs_lo} << 3) + ({4'b0, abs_lo} << 1);

    always_comb
    begin
        cfg_wdata.code      = in_ch.event_code;
        cfg_wdata.absolute  = in_ch.axis_absolute;
        cfg_wdata.one_sided = lo_x10 <= {4'b0, abs_hi};
        cfg_wdata.lo        = in_ch.axis_min;
        cfg_wdata.hi        = in_ch.axis_max;
    end

    always_ff @(posedge clk)
    begin
        if (cfg_mem_we)
            axis_cfg_mem[in_ch.slot[AIW-1:0]] <= cfg_wdata;
        if (cfg_re)
            cfg_rd_reg <= axis_cfg_mem[cnt_reg[AIW-1:0]];
    end

    // Axis value and snapshot memories; unwritten entries read as zero
    logic signed [VALUE_W-1:0] now_mem  [MAX_AXES];
    logic signed [VALUE_W-1:0] snap_mem [MAX_AXES];
    logic signed [VALUE_W-1:0] now_rd_reg;
    logic signed [VALUE_W-1:0] snap_rd_reg;
    logic [MAX_AXES-1:0]       now_vld_reg;
    logic [MAX_AXES-1:0]       snap_vld_reg;
    logic                      now_rd_vld_reg;
    logic                      snap_rd_vld_reg;
    logic signed [VALUE_W-1:0] now_q;
    logic signed [VALUE_W-1:0] snap_q;
    logic                      now_re;
    logic                      snap_re;
    logic [AIW-1:0]            now_raddr;
    logic                      now_we;
    logic [AIW-1:0]            now_waddr;
    logic signed [VALUE_W-1:0] now_wdata;
    logic                      snap_we;
    logic signed [VALUE_W-1:0] snap_wdata;

    assign now_q  = now_rd_vld_reg ? now_rd_reg : '0;
    assign snap_q = snap_rd_vld_reg ? snap_rd_reg : '0;

    always_ff @(posedge clk)
    begin
        if (now_we)
            now_mem[now_waddr] <= now_wdata;
        if (now_re)
            now_rd_reg <= now_mem[now_raddr];
        if (snap_we)
            snap_mem[cnt_reg[AIW-1:0]] <= snap_wdata;
        if (snap_re)
            snap_rd_reg <= snap_mem[cnt_reg[AIW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_vld_reg     <= '0;
            snap_vld_reg    <= '0;
            now_rd_vld_reg  <= 1'b0;
            snap_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (now_re)
                now_rd_vld_reg <= now_vld_reg[now_raddr];
            if (snap_re)
                snap_rd_vld_reg <= snap_vld_reg[cnt_reg[AIW-1:0]];
            if (now_we)
                now_vld_reg[now_waddr] <= 1'b1;
            if (snap_we)
                snap_vld_reg[cnt_reg[AIW-1:0]] <= 1'b1;
        end
    end

    // Scan compares and walk decisions
    logic bhit;
    logic ahit;
    logic out_free;
    logic need_emit;
    logic advance;
    logic out_load;

    assign bhit = cmp_vld_reg && (btn_rd_reg == op_code_reg);
    assign ahit = cmp_vld_reg && (cfg_rd_reg.code == op_code_reg)
                  && (cfg_rd_reg.absolute == op_abs_reg);
    assign out_free = !out_valid_reg || out_ch.ready;
    assign need_emit = op_focus_reg ? (now_q != 0)
                     : (first_done_reg && (cnt_reg < NB_W'(na)) && (now_q != snap_q));
    assign advance = !need_emit || out_free;
    assign out_load = ((state_reg == S_WALK_CHK) && advance && need_emit)
                      || ((state_reg == S_BTN_RPT) && out_free);

    assign btn_re  = (state_reg == S_BSCAN) && !bhit && (cnt_reg < nb);
    assign cfg_re  = (state_reg == S_ASCAN) && !ahit && (cnt_reg < NB_W'(na));
    assign snap_re = (state_reg == S_WALK_RD) && (cnt_reg < NB_W'(walk_lim_reg));
    assign now_re  = snap_re || ((state_reg == S_ASCAN) && ahit && !op_abs_reg);
    assign now_raddr = (state_reg == S_WALK_RD) ? cnt_reg[AIW-1:0] : cmp_idx_reg[AIW-1:0];

    // Relative sum, normaliser result and reported differences
    logic signed [51:0]        rel_sum;
    logic signed [51:0]        quo_signed;
    logic signed [51:0]        norm_full;
    logic signed [VALUE_W-1:0] norm_val;
    logic signed [VALUE_W-1:0] frame_change;
    logic signed [VALUE_W-1:0] focus_change;

    assign rel_sum    = 52'(now_q) + (52'(op_value_reg) <<< 16);
    assign quo_signed = neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});
    assign norm_full  = sym_reg ? quo_signed - 52'sd65536 : quo_signed;
    assign norm_val   = div_zero_reg ? '0 : sat32(norm_full);
    assign frame_change = sat32(52'(now_q) - 52'(snap_q));
    assign focus_change = sat32(-52'(now_q));

    always_comb
    begin
        now_we     = 1'b0;
        now_waddr  = idx_reg;
        now_wdata  = '0;
        snap_we    = 1'b0;
        snap_wdata = op_focus_reg ? '0 : now_q;
        case (state_reg)
            S_REL_WR:
            begin
                now_we    = 1'b1;
                now_wdata = sat32(rel_sum);
            end
            S_DIV_END:
            begin
                now_we    = 1'b1;
                now_wdata = norm_val;
            end
            S_WALK_CHK:
            begin
                snap_we   = advance;
                now_we    = advance && op_focus_reg;
                now_waddr = cnt_reg[AIW-1:0];
            end
            default: ;
        endcase
    end

    // Divider step: restoring, one quotient bit per cycle
    logic [33:0] trial;
    logic        trial_ok;
    assign trial    = {rem_reg, dvd_reg[DIV_STEPS-1]};
    assign trial_ok = trial >= {1'b0, dsr_reg};

    // Absolute event set-up from the matched slot
    logic signed [32:0] num_s;
    logic signed [32:0] den_s;
    logic [32:0]        num_mag;
    logic [32:0]        den_mag;
    assign num_s   = 33'(op_value_reg) - 33'(cfg_rd_reg.lo);
    assign den_s   = 33'(cfg_rd_reg.hi) - 33'(cfg_rd_reg.lo);
    assign num_mag = num_s[32] ? 33'(-num_s) : 33'(num_s);
    assign den_mag = den_s[32] ? 33'(-den_s) : 33'(den_s);

    // Main state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            cmp_vld_reg      <= 1'b0;
            cmp_idx_reg      <= '0;
            idx_reg          <= '0;
            op_code_reg      <= '0;
            op_value_reg     <= '0;
            op_abs_reg       <= 1'b0;
            op_focus_reg     <= 1'b0;
            walk_lim_reg     <= '0;
            first_done_reg   <= 1'b0;
            pressed_now_reg  <= '0;
            pressed_snap_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_reg          <= '0;
            rem_reg          <= '0;
            dvd_reg          <= '0;
            quo_reg          <= '0;
            dsr_reg          <= '0;
            div_cnt_reg      <= '0;
            neg_reg          <= 1'b0;
            sym_reg          <= 1'b0;
            div_zero_reg     <= 1'b0;
        end
        else
        begin
            // Output register: load a new report, or free it once taken
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg     <= '0;
                    cmp_vld_reg <= 1'b0;
                    if (accept)
                    begin
                        op_code_reg  <= in_ch.event_code;
                        op_value_reg <= in_ch.event_value;
                        op_abs_reg   <= (in_ch.event_type == EVT_ABS);
                        case (in_ch.action)
                            ACT_EVENT:
                            begin
                                if (in_ch.event_type == EVT_KEY)
                                    state_reg <= S_BSCAN;
                                else if (in_ch.event_type == EVT_ABS
                                         || in_ch.event_type == EVT_REL)
                                    state_reg <= S_ASCAN;
                            end
                            ACT_FRAME:
                            begin
                                op_focus_reg <= 1'b0;
                                walk_lim_reg <= NA_W'(MAX_AXES);
                                state_reg    <= S_WALK_RD;
                            end
                            ACT_FOCUS_LOST:
                            begin
                                op_focus_reg <= 1'b1;
                                walk_lim_reg <= na;
                                state_reg    <= S_WALK_RD;
                            end
                            default: ;
                        endcase
                    end
                end

                // Lowest matching button slot in use
                S_BSCAN:
                begin
                    if (bhit)
                    begin
                        pressed_now_reg[cmp_idx_reg[BIW-1:0]] <= (op_value_reg != 0);
                        state_reg <= S_IDLE;
                    end
                    else if (cnt_reg < nb)
                    begin
                        cmp_vld_reg <= 1'b1;
                        cmp_idx_reg <= cnt_reg;
                        cnt_reg     <= cnt_reg + 1'b1;
                    end
                    else
                        state_reg <= S_IDLE;
                end

                // Lowest matching axis slot of the event's kind
                S_ASCAN:
                begin
                    if (ahit)
                    begin
                        idx_reg <= cmp_idx_reg[AIW-1:0];
                        if (op_abs_reg)
                        begin
                            rem_reg      <= '0;
                            dvd_reg      <= cfg_rd_reg.one_sided ? {1'b0, num_mag, 16'b0}
                                                                 : {num_mag, 17'b0};
                            quo_reg      <= '0;
                            dsr_reg      <= den_mag;
                            div_cnt_reg  <= '0;
                            neg_reg      <= num_s[32] ^ den_s[32];
                            sym_reg      <= !cfg_rd_reg.one_sided;
                            div_zero_reg <= (den_s == 0);
                            state_reg    <= (den_s == 0) ? S_DIV_END : S_DIV;
                        end
                        else
                            state_reg <= S_REL_WR;
                    end
                    else if (cnt_reg < NB_W'(na))
                    begin
                        cmp_vld_reg <= 1'b1;
                        cmp_idx_reg <= cnt_reg;
                        cnt_reg     <= cnt_reg + 1'b1;
                    end
                    else
                        state_reg <= S_IDLE;
                end

                S_REL_WR:
                    state_reg <= S_IDLE;

                S_DIV:
                begin
                    rem_reg     <= trial_ok ? 33'(trial - {1'b0, dsr_reg}) : trial[32:0];
                    dvd_reg     <= {dvd_reg[DIV_STEPS-2:0], 1'b0};
                    quo_reg     <= {quo_reg[DIV_STEPS-2:0], trial_ok};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 6'(DIV_STEPS - 1))
                        state_reg <= S_DIV_END;
                end

                S_DIV_END:
                    state_reg <= S_IDLE;

                // Axis walk for frame update and focus loss
                S_WALK_RD:
                begin
                    if (cnt_reg < NB_W'(walk_lim_reg))
                        state_reg <= S_WALK_CHK;
                    else if (!op_focus_reg && !first_done_reg)
                    begin
                        pressed_snap_reg <= pressed_now_reg;
                        first_done_reg   <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                    else
                        state_reg <= S_BTN_RPT;
                end

                S_WALK_CHK:
                begin
                    if (advance)
                    begin
                        if (need_emit)
                        begin
                            out_reg.kind   <= RPT_AXIS;
                            out_reg.idx    <= cnt_reg[AIDX_W-1:0];
                            out_reg.value  <= op_focus_reg ? '0 : now_q;
                            out_reg.change <= op_focus_reg ? focus_change : frame_change;
                            out_reg.down    <= '0;
                            out_reg.changed <= '0;
                            out_reg.last    <= 1'b0;
                        end
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_WALK_RD;
                    end
                end

                // Closing button report
                S_BTN_RPT:
                begin
                    if (out_free)
                    begin
                        out_reg.kind   <= RPT_BUTTON;
                        out_reg.idx    <= '0;
                        out_reg.value  <= '0;
                        out_reg.change <= '0;
                        out_reg.last   <= 1'b1;
                        if (op_focus_reg)
                        begin
                            out_reg.down     <= '0;
                            out_reg.changed  <= MASK_W'(pressed_now_reg & btn_mask);
                            pressed_now_reg  <= pressed_now_reg & ~btn_mask;
                            pressed_snap_reg <= pressed_snap_reg & ~btn_mask;
                        end
                        else
                        begin
                            out_reg.down     <= MASK_W'(pressed_now_reg & btn_mask);
                            out_reg.changed  <= MASK_W'((pressed_now_reg ^ pressed_snap_reg)
                                                        & btn_mask);
                            pressed_snap_reg <= pressed_now_reg;
                            first_done_reg   <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Result channel
    assign out_ch.valid           = out_valid_reg;
    assign out_ch.report_kind     = out_reg.kind;
    assign out_ch.axis_index      = out_reg.idx;
    assign out_ch.axis_value      = out_reg.value;
    assign out_ch.axis_change     = out_reg.change;
    assign out_ch.buttons_down    = out_reg.down;
    assign out_ch.buttons_changed = out_reg.changed;
    assign out_ch.last            = out_reg.last;

    // Checks
    ap_axis_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.report_kind == RPT_AXIS
        |-> out_ch.buttons_down == '0 && out_ch.buttons_changed == '0 && !out_ch.last)
        else $error("axis report carries button data or end mark");

    ap_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_cnt_reg < 6'(DIV_STEPS))
        else $error("divider ran past its step count");

    ap_frame_walk: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.action == ACT_FRAME |=> state_reg == S_WALK_RD && cnt_reg == '0)
        else $error("frame update did not start the axis walk");

    ap_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK_CHK |-> cnt_reg < NB_W'(walk_lim_reg))
        else $error("axis walk beyond its limit");

endmodule

// ----- tb/gest_tracker_checker.sv -----
// Checker for the gamepad event state tracker: predicts reports and compares them.
`timescale 1ns / 100ps

module gest_tracker_checker import gest_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    gest_in_if                    in_ch,
    gest_out_if                   out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    reports_checked
);

    typedef struct {
        logic                      kind;
        logic [AIDX_W-1:0]         idx;
        logic signed [VALUE_W-1:0] val;
        logic signed [VALUE_W-1:0] chg;
        logic [MASK_W-1:0]         down;
        logic [MASK_W-1:0]         changed;
        logic                      last;
    } report_t;

    report_t expected_reports[$];

    // Shadow copy of the tracker state
    logic [CODE_W-1:0] button_codes [MAX_BUTTONS_DEF];
    logic [CODE_W-1:0] axis_codes   [MAX_AXES_DEF];
    logic              axis_is_abs  [MAX_AXES_DEF];
    longint            axis_lo      [MAX_AXES_DEF];
    longint            axis_hi      [MAX_AXES_DEF];
    longint            axis_val     [MAX_AXES_DEF];
    longint            axis_snap    [MAX_AXES_DEF];
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] pressed_snap;
    bit                seen_first_frame;
    int                nb_reg;
    int                na_reg;

    function automatic longint sat32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Q16.16 scaling of an absolute axis, one-sided or symmetric
    function automatic longint scale_axis(longint v, longint lo, longint hi);
        longint span;
        longint alo;
        longint ahi;
        span = hi - lo;
        alo  = lo < 0 ? -lo : lo;
        ahi  = hi < 0 ? -hi : hi;
        if (span == 0)
            return 0;
        if (alo <= ahi / 10)
            return sat32(((v - lo) * 65536) / span);
        return sat32(((v - lo) * 131072) / span - 65536);
    endfunction

    function automatic void add_report(logic kind, int idx, longint val, longint chg,
                                       logic [MASK_W-1:0] down, logic [MASK_W-1:0] changed);
        report_t r;
        r.kind    = kind;
        r.idx     = idx[AIDX_W-1:0];
        r.val     = val[VALUE_W-1:0];
        r.chg     = chg[VALUE_W-1:0];
        r.down    = down;
        r.changed = changed;
        r.last    = 1'b0;
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    task automatic check_field(string name, logic [MASK_W-1:0] exp_v, logic [MASK_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Prediction on input and config transactions, comparison on result transactions
    always @(posedge clk or negedge rst_n)
    begin
        int nb;
        int na;
        int n;
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] released;
        longint ev_val;
        report_t got;
        report_t exp_r;
        if (!rst_n)
        begin
            expected_reports.delete();
            foreach (axis_val[i])
            begin
                axis_val[i]  = 0;
                axis_snap[i] = 0;
            end
            pressed          = '0;
            pressed_snap     = '0;
            seen_first_frame = 0;
            nb_reg           = 0;
            na_reg           = 0;
            fail_count       = 0;
            reports_checked  = 0;
            pending          = 0;
        end
        else
        begin
            // result side
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind    = out_ch.report_kind;
                got.idx     = out_ch.axis_index;
                got.val     = out_ch.axis_value;
                got.chg     = out_ch.axis_change;
                got.down    = out_ch.buttons_down;
                got.changed = out_ch.buttons_changed;
                got.last    = out_ch.last;
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none, got kind %0d idx %0d",
                             $time, got.kind, got.idx);
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_reports.pop_front();
                    check_field("report_kind", MASK_W'(exp_r.kind), MASK_W'(got.kind));
                    check_field("axis_index", MASK_W'(exp_r.idx), MASK_W'(got.idx));
                    check_field("axis_value", MASK_W'(unsigned'(exp_r.val)),
                                MASK_W'(unsigned'(got.val)));
                    check_field("axis_change", MASK_W'(unsigned'(exp_r.chg)),
                                MASK_W'(unsigned'(got.chg)));
                    check_field("buttons_down", exp_r.down, got.down);
                    check_field("buttons_changed", exp_r.changed, got.changed);
                    check_field("last", MASK_W'(exp_r.last), MASK_W'(got.last));
                end
                reports_checked++;
            end

            if (cfg_we)
            begin
                if (cfg_index == REG_NUM_BUTTONS)
                    nb_reg = int'(cfg_data);
                else if (cfg_index == REG_NUM_AXES)
                    na_reg = int'(cfg_data[NA_W-1:0]);
            end

            // input side
            if (in_ch.valid && in_ch.ready)
            begin
                nb     = nb_reg > MAX_BUTTONS_DEF ? MAX_BUTTONS_DEF : nb_reg;
                na     = na_reg > MAX_AXES_DEF ? MAX_AXES_DEF : na_reg;
                mask   = nb >= 64 ? '1 : ((64'd1 << nb) - 64'd1);
                ev_val = longint'(in_ch.event_value);
                n      = expected_reports.size();
                case (in_ch.action)
                    ACT_LOAD_BUTTON: button_codes[in_ch.slot] = in_ch.event_code;
                    ACT_LOAD_AXIS:
                    begin
                        if (in_ch.slot < MAX_AXES_DEF)
                        begin
                            axis_codes[in_ch.slot]  = in_ch.event_code;
                            axis_is_abs[in_ch.slot] = in_ch.axis_absolute;
                            axis_lo[in_ch.slot]     = longint'(in_ch.axis_min);
                            axis_hi[in_ch.slot]     = longint'(in_ch.axis_max);
                        end
                    end
                    ACT_EVENT:
                    begin
                        if (in_ch.event_type == EVT_KEY)
                        begin
                            for (int i = 0; i < nb; i++)
                            begin
                                if (button_codes[i] == in_ch.event_code)
                                begin
                                    pressed[i] = (ev_val != 0);
                                    break;
                                end
                            end
                        end
                        else if (in_ch.event_type == EVT_ABS
                                 || in_ch.event_type == EVT_REL)
                        begin
                            for (int i = 0; i < na; i++)
                            begin
                                if (axis_is_abs[i] == (in_ch.event_type == EVT_ABS)
                                    && axis_codes[i] == in_ch.event_code)
                                begin
                                    if (axis_is_abs[i])
                                        axis_val[i] = scale_axis(ev_val, axis_lo[i], axis_hi[i]);
                                    else
                                        axis_val[i] = sat32(axis_val[i] + ev_val * 65536);
                                    break;
                                end
                            end
                        end
                    end
                    ACT_FRAME:
                    begin
                        if (seen_first_frame)
                        begin
                            for (int i = 0; i < na; i++)
                                if (axis_val[i] != axis_snap[i])
                                    add_report(RPT_AXIS, i, axis_val[i],
                                               sat32(axis_val[i] - axis_snap[i]), '0, '0);
                            add_report(RPT_BUTTON, 0, '0, '0, pressed & mask,
                                       (pressed ^ pressed_snap) & mask);
                        end
                        axis_snap        = axis_val;
                        pressed_snap     = pressed;
                        seen_first_frame = 1;
                    end
                    ACT_FOCUS_LOST:
                    begin
                        released = pressed & mask;
                        for (int i = 0; i < na; i++)
                        begin
                            if (axis_val[i] != 0)
                                add_report(RPT_AXIS, i, '0, sat32(-axis_val[i]), '0, '0);
                            axis_val[i]  = 0;
                            axis_snap[i] = 0;
                        end
                        pressed      = pressed & ~mask;
                        pressed_snap = pressed_snap & ~mask;
                        add_report(RPT_BUTTON, 0, '0, '0, pressed & mask, released);
                    end
                    default: ;
                endcase
                if (expected_reports.size() > n)
                    expected_reports[expected_reports.size()-1].last = 1'b1;
            end
            pending = expected_reports.size();
        end
    end

endmodule

// ----- tb/tb_gamepad_event_state_tracker.sv -----
// Testbench top for the gamepad event state tracker: stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_gamepad_event_state_tracker;
    import gest_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 120;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    reports_checked;
    int                    cycles;
    int                    items_sent;
    int                    frames_sent;
    bit                    calm;

    // Host-side copy of the loaded tables, used to aim events at real slots
    logic [CODE_W-1:0] btn_code_sh [64];
    logic [CODE_W-1:0] ax_code_sh  [16];
    logic              ax_abs_sh   [16];
    int                ax_lo_sh    [16];
    int                ax_hi_sh    [16];

    gest_in_if  in_ch ();
    gest_out_if out_ch ();

    gamepad_event_state_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gest_tracker_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .reports_checked (reports_checked)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result-side back-pressure
    initial
    begin
        int w;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            w = calm ? 0 : $urandom_range(0, 8);
            out_ch.ready = 1'b0;
            repeat (w) @(negedge clk);
            out_ch.ready = 1'b1;
            do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // One input transaction; called at a falling edge
    task automatic send_item(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] slt,
                             logic [ETYPE_W-1:0] et, logic [CODE_W-1:0] code,
                             logic [31:0] val, logic ab, logic [31:0] lo, logic [31:0] hi);
        int w;
        w = calm ? 0 : $urandom_range(0, 8);
        if (w > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (w) @(negedge clk);
        end
        in_ch.action        = act;
        in_ch.slot          = slt;
        in_ch.event_type    = et;
        in_ch.event_code    = code;
        in_ch.event_value   = val;
        in_ch.axis_absolute = ab;
        in_ch.axis_min      = lo;
        in_ch.axis_max      = hi;
        in_ch.valid         = 1'b1;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        items_sent++;
        if (act == ACT_FRAME)
            frames_sent++;
    endtask

    task automatic load_button(int s, logic [CODE_W-1:0] code);
        btn_code_sh[s] = code;
        send_item(ACT_LOAD_BUTTON, SLOT_W'(s), EVT_KEY, code, $urandom, 1'($urandom),
                  $urandom, $urandom);
    endtask

    task automatic load_axis(int s, logic [CODE_W-1:0] code, logic ab, int lo, int hi);
        if (s < 16)
        begin
            ax_code_sh[s] = code;
            ax_abs_sh[s]  = ab;
            ax_lo_sh[s]   = lo;
            ax_hi_sh[s]   = hi;
        end
        send_item(ACT_LOAD_AXIS, SLOT_W'(s), EVT_KEY, code, $urandom, ab, lo, hi);
    endtask

    task automatic key_event(logic [CODE_W-1:0] code, logic [31:0] val);
        send_item(ACT_EVENT, SLOT_W'($urandom), EVT_KEY, code, val, 1'($urandom),
                  $urandom, $urandom);
    endtask

    task automatic axis_event(logic [ETYPE_W-1:0] et, logic [CODE_W-1:0] code,
                              logic [31:0] val);
        send_item(ACT_EVENT, SLOT_W'($urandom), et, code, val, 1'($urandom),
                  $urandom, $urandom);
    endtask

    task automatic plain_item(logic [ACTION_W-1:0] act);
        send_item(act, SLOT_W'($urandom), ETYPE_W'($urandom), CODE_W'($urandom), $urandom,
                  1'($urandom), $urandom, $urandom);
    endtask

    // Wait for every outstanding report, then give the block a settling pause to go idle
    task automatic drain();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Random value aimed near an axis range, near zero, or anywhere
    function automatic logic [31:0] pick_axis_value(int s);
        case ($urandom_range(0, 4))
            0: return ax_lo_sh[s];
            1: return ax_hi_sh[s];
            2: return ax_lo_sh[s] + $signed($urandom_range(0, 200)) - 100;
            3: return $signed($urandom_range(0, 16)) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_item();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            s = $urandom_range(0, 63);
            key_event(btn_code_sh[s], ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom);
        end
        else if (r < 58)
        begin
            s = $urandom_range(0, 15);
            axis_event(ax_abs_sh[s] ? EVT_ABS : EVT_REL, ax_code_sh[s], pick_axis_value(s));
        end
        else if (r < 64)
        begin
            axis_event(ETYPE_W'($urandom_range(0, 3)), CODE_W'($urandom_range(0, 1023)),
                       $urandom);
        end
        else if (r < 82)
        begin
            plain_item(ACT_FRAME);
        end
        else if (r < 86)
        begin
            plain_item(ACT_FOCUS_LOST);
        end
        else if (r < 91)
        begin
            load_button($urandom_range(0, 63), CODE_W'($urandom_range(0, 767)));
        end
        else if (r < 97)
        begin
            s = $urandom_range(0, 63);
            if ($urandom_range(0, 1))
                load_axis(s, CODE_W'($urandom_range(0, 767)), 1'($urandom), $urandom,
                          $urandom);
            else
                load_axis(s, CODE_W'($urandom_range(0, 767)), 1'($urandom),
                          -$urandom_range(0, 300), $urandom_range(0, 3000));
        end
        else
        begin
            plain_item(ACTION_W'($urandom_range(5, 7)));
        end
    endtask

    initial
    begin
        int nb_set [6] = '{64, 127, 0, 17, 1, 40};
        int na_set [6] = '{16, 31, 0, 5, 1, 9};
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_NUM_BUTTONS;
        cfg_data    = '0;
        calm        = 1'b0;
        cycles      = 0;
        items_sent  = 0;
        frames_sent = 0;
        in_ch.valid = 1'b0;
        in_ch.action = ACT_LOAD_BUTTON;
        in_ch.slot = '0;
        in_ch.event_type = EVT_KEY;
        in_ch.event_code = '0;
        in_ch.event_value = '0;
        in_ch.axis_absolute = 1'b0;
        in_ch.axis_min = '0;
        in_ch.axis_max = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(REG_NUM_BUTTONS, 7'd64);
        write_reg(REG_NUM_AXES, 7'd16);

        // Fill every slot so no scan ever reads an empty entry; slot 1 repeats slot 0's code
        load_button(0, 10'd0);
        load_button(1, 10'd0);
        load_button(63, 10'd767);
        for (int i = 2; i < 63; i++)
            load_button(i, CODE_W'($urandom_range(1, 766)));
        load_axis(0, 10'd100, 1'b1, 0, 1023);
        load_axis(1, 10'd101, 1'b1, -32768, 32767);
        load_axis(2, 10'd102, 1'b1, 5, 5);
        load_axis(3, 10'd103, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        load_axis(4, 10'd104, 1'b0, 0, 0);
        load_axis(5, 10'd104, 1'b1, 255, -255);
        load_axis(6, 10'd767, 1'b0, 0, 0);
        load_axis(7, 10'd0, 1'b1, -10, 100);
        for (int i = 8; i < 16; i++)
            load_axis(i, CODE_W'($urandom_range(0, 767)), 1'($urandom),
                      -$urandom_range(0, 500), $urandom_range(0, 5000));
        load_axis(16, 10'd100, 1'b1, 7, 9);
        load_axis(63, 10'd101, 1'b0, 0, 0);

        // Directed part: focus loss before first frame, silent first frame, extremes
        plain_item(ACT_FOCUS_LOST);
        key_event(10'd0, 32'd1);
        plain_item(ACT_FRAME);
        key_event(10'd767, 32'h8000_0000);
        key_event(10'd0, 32'd0);
        axis_event(EVT_ABS, 10'd100, 32'd1023);
        axis_event(EVT_ABS, 10'd101, 32'h8000_0000);
        axis_event(EVT_ABS, 10'd102, 32'd77);
        axis_event(EVT_ABS, 10'd103, 32'h7FFF_FFFF);
        axis_event(EVT_ABS, 10'd104, 32'd0);
        axis_event(EVT_REL, 10'd104, 32'h7FFF_FFFF);
        axis_event(EVT_REL, 10'd767, 32'hFFFF_FFFF);
        axis_event(EVT_ABS, 10'd0, 32'h8000_0000);
        axis_event(2'd3, 10'd100, 32'd5);
        axis_event(EVT_KEY, 10'd1023, 32'd1);
        plain_item(3'd5);
        plain_item(3'd7);
        plain_item(ACT_FRAME);
        axis_event(EVT_REL, 10'd104, 32'h8000_0000);
        axis_event(EVT_REL, 10'd104, 32'h8000_0000);
        plain_item(ACT_FRAME);
        plain_item(ACT_FRAME);
        plain_item(ACT_FOCUS_LOST);

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_reg(REG_NUM_BUTTONS, CFG_DATA_W'(nb_set[p]));
            write_reg(REG_NUM_AXES, CFG_DATA_W'(na_set[p]));
            calm = (p == 3);
            for (int k = 0; k < 12; k++)
                random_item();
            plain_item(ACT_FRAME);
        end

        drain();
        $display("Covered %0d input transactions (%0d frame updates), %0d reports checked,",
                 items_sent, frames_sent, reports_checked);
        $display("over six register settings including both limits and out-of-range values.");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/gest_pkg.sv
hdl/gest_in_if.sv
hdl/gamepad_event_state_tracker.sv
tb/gest_tracker_checker.sv
tb/tb_gamepad_event_state_tracker.sv
